// ===== sv/wht_pkg.sv =====
// ============================================================================
// wht_pkg - shared types and constants
// Payload structs, widths and register map of the Walsh-Hadamard transform.
// ============================================================================
`default_nettype none

package wht_pkg;

    localparam int LOG_MAX  = 10;                  // largest supported log2 length
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = SAMPLE_W + LOG_MAX;  // growth of one bit per stage
    localparam int POS_W    = LOG_MAX;
    localparam int CNT_W    = LOG_MAX + 1;         // holds the frame length itself
    localparam int LOG_W    = 4;                   // log_size register width
    localparam int DEPTH    = 1 << LOG_MAX;

    // register map, index = paddr[2]
    localparam logic REG_LOG_SIZE = 1'b0;
    localparam logic REG_INVERSE  = 1'b1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [POS_W-1:0]         position;
        logic                     last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/walsh_hadamard_transform_core.sv =====
// ============================================================================
// walsh_hadamard_transform_core - fast Walsh-Hadamard transform
// Frame loader, in-place radix-2 butterfly sequencer and coefficient readout.
// ============================================================================
// A load item writes one sample. When the last sample of a 2^L frame arrives
// the block runs (2^L/2)*L butterflies on one shared adder, each in the steps
// read a, read b, write a+b, write a-b, because the frame memory has one read
// and one write port. Input stall is high for that whole time. A read item
// goes through the memory read register, then the output register, and is held
// back while a stalled result still holds the output register; a read before
// the transform is done, or past the frame end, gives no transfer.
// Inverse mode folds the flooring shift by L into the final butterfly stage.
// Writing log_size discards any partial or unread frame.
`default_nettype none

module walsh_hadamard_transform_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire wht_pkg::t_in_item i_in_data,
    // output channel
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      wht_pkg::t_out_item o_out_data,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);

    localparam int LM = wht_pkg::LOG_MAX;
    localparam int CW = wht_pkg::COEF_W;
    localparam int NW = wht_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_WRS  = 3'd3;
    localparam logic [2:0] S_WRD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // configuration
    logic [wht_pkg::LOG_W-1:0] r_log_size;
    logic                      r_inverse;

    // control state
    logic [2:0]    r_state, n_state;
    logic [LM-1:0] r_load_cnt, n_load_cnt;
    logic [LM-1:0] r_read_cnt, n_read_cnt;
    logic          r_ready, n_ready;
    logic [LM-1:0] r_span, n_span;
    logic [LM-2:0] r_bf, n_bf;
    logic          r_out_valid, n_out_valid;

    // payload
    logic signed [CW-1:0] r_a, r_b;
    logic [LM-1:0]        r_pend_pos;
    logic                 r_pend_last;
    wht_pkg::t_out_item   r_out;

    // frame memory
    logic signed [CW-1:0] r_mem [wht_pkg::DEPTH];
    logic signed [CW-1:0] r_rdata;
    logic                 mem_we, mem_re;
    logic [LM-1:0]        mem_waddr, mem_raddr;
    logic signed [CW-1:0] mem_wdata;

    logic [wht_pkg::LOG_W-1:0] lg;
    logic [NW-1:0]        frame_n;
    logic [NW-1:0]        half_m1;
    logic [LM-1:0]        mask, jx, addr_a, addr_b;
    logic                 last_stage;
    logic                 in_xfer, cfg_wr;
    logic                 out_free;
    logic signed [CW-1:0] bf_b, bf_y;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == wht_pkg::REG_INVERSE) ? {31'd0, r_inverse}
                                                       : {28'd0, r_log_size};

    assign lg      = (r_log_size > wht_pkg::LOG_W'(LM)) ? wht_pkg::LOG_W'(LM) : r_log_size;
    assign frame_n = NW'(1) << lg;
    assign half_m1 = (frame_n >> 1) - NW'(1);

    // butterfly addresses: insert a zero at the span bit of the butterfly index
    assign mask       = r_span - LM'(1);
    assign jx         = LM'(r_bf);
    assign addr_a     = ((jx & ~mask) << 1) | (jx & mask);
    assign addr_b     = addr_a | r_span;
    assign last_stage = ({1'b0, r_span, 1'b0} == {1'b0, frame_n});

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign bf_b = (r_state == S_WRS) ? r_rdata : r_b;

    wht_butterfly u_bfly (
        .i_a        (r_a),
        .i_b        (bf_b),
        .i_sub      (r_state == S_WRD),
        .i_shift_en (r_inverse && last_stage),
        .i_shift    (lg),
        .o_y        (bf_y)
    );

    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_read_cnt  = r_read_cnt;
        n_ready     = r_ready;
        n_span      = r_span;
        n_bf        = r_bf;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_load_cnt;
        mem_raddr   = r_read_cnt;
        mem_wdata   = CW'(i_in_data.sample);

        case (r_state)
            S_IDLE: begin
                if (in_xfer && i_in_data.kind == wht_pkg::KIND_LOAD) begin
                    mem_we     = 1'b1;
                    n_ready    = 1'b0;
                    n_read_cnt = '0;
                    if ((NW'(r_load_cnt) + NW'(1)) == frame_n) begin
                        n_load_cnt = '0;
                        n_span     = LM'(1);
                        n_bf       = '0;
                        if (lg == '0) begin
                            n_ready = 1'b1;
                        end else begin
                            n_state = S_RDA;
                        end
                    end else begin
                        n_load_cnt = r_load_cnt + LM'(1);
                    end
                end else if (in_xfer && r_ready) begin
                    mem_re = 1'b1;
                    if ((NW'(r_read_cnt) + NW'(1)) == frame_n) begin
                        n_read_cnt = '0;
                        n_ready    = 1'b0;
                    end else begin
                        n_read_cnt = r_read_cnt + LM'(1);
                    end
                    n_state = S_OUT;
                end
            end
            S_RDA: begin
                mem_re    = 1'b1;
                mem_raddr = addr_a;
                n_state   = S_RDB;
            end
            S_RDB: begin
                mem_re    = 1'b1;
                mem_raddr = addr_b;
                n_state   = S_WRS;
            end
            S_WRS: begin
                mem_we    = 1'b1;
                mem_waddr = addr_a;
                mem_wdata = bf_y;
                n_state   = S_WRD;
            end
            S_WRD: begin
                mem_we    = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = bf_y;
                if (NW'(r_bf) == half_m1) begin
                    n_bf = '0;
                    if (last_stage) begin
                        n_ready = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_span  = r_span << 1;
                        n_state = S_RDA;
                    end
                end else begin
                    n_bf    = r_bf + (LM-1)'(1);
                    n_state = S_RDA;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // the user must write log_size only while idle; the block does not enforce it
        if (cfg_wr && paddr[2] == wht_pkg::REG_LOG_SIZE) begin
            n_load_cnt = '0;
            n_read_cnt = '0;
            n_ready    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_cnt  <= '0;
            r_read_cnt  <= '0;
            r_ready     <= 1'b0;
            r_span      <= LM'(1);
            r_bf        <= '0;
            r_out_valid <= 1'b0;
            r_log_size  <= wht_pkg::LOG_W'(10);
            r_inverse   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_read_cnt  <= n_read_cnt;
            r_ready     <= n_ready;
            r_span      <= n_span;
            r_bf        <= n_bf;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                if (paddr[2] == wht_pkg::REG_LOG_SIZE) begin
                    r_log_size <= pwdata[wht_pkg::LOG_W-1:0];
                end else begin
                    r_inverse <= pwdata[0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_RDB) begin
            r_a <= r_rdata;
        end
        if (r_state == S_WRS) begin
            r_b <= r_rdata;
        end
        if (r_state == S_IDLE && mem_re) begin
            r_pend_pos  <= r_read_cnt;
            r_pend_last <= ((NW'(r_read_cnt) + NW'(1)) == frame_n);
        end
        if (r_state == S_OUT && out_free) begin
            r_out.coefficient <= r_rdata;
            r_out.position    <= r_pend_pos;
            r_out.last        <= r_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/wht_butterfly.sv =====
// ============================================================================
// wht_butterfly - shared butterfly arithmetic
// Sum or difference of two coefficients, with optional flooring right shift
// applied on the final stage of an inverse transform.
// ============================================================================
`default_nettype none

module wht_butterfly (
    input  wire logic signed [wht_pkg::COEF_W-1:0] i_a,
    input  wire logic signed [wht_pkg::COEF_W-1:0] i_b,
    input  wire logic                              i_sub,
    input  wire logic                              i_shift_en,
    input  wire logic [wht_pkg::LOG_W-1:0]         i_shift,
    output      logic signed [wht_pkg::COEF_W-1:0] o_y
);

    logic signed [wht_pkg::COEF_W:0] a_ext;
    logic signed [wht_pkg::COEF_W:0] b_ext;
    logic signed [wht_pkg::COEF_W:0] raw;
    logic signed [wht_pkg::COEF_W:0] shifted;

    always_comb begin
        a_ext   = {i_a[wht_pkg::COEF_W-1], i_a};
        b_ext   = {i_b[wht_pkg::COEF_W-1], i_b};
        raw     = i_sub ? (a_ext - b_ext) : (a_ext + b_ext);
        // arithmetic shift floors toward minus infinity
        shifted = i_shift_en ? (raw >>> i_shift) : raw;
        o_y     = shifted[wht_pkg::COEF_W-1:0];
    end

endmodule

`default_nettype wire

// ===== test/walsh_hadamard_transform_core_tb.sv =====
// ============================================================================
// walsh_hadamard_transform_core_tb - self-checking testbench
// Loads sample frames, reads the coefficients back and compares each one with
// a behavioral Walsh-Hadamard predictor, across frame sizes and both scalings.
// ============================================================================
`default_nettype none

module walsh_hadamard_transform_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 40000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    wht_pkg::t_in_item    in_data;
    logic                 out_valid;
    logic                 out_stall;
    wht_pkg::t_out_item   out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    walsh_hadamard_transform_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // transform predictor
    // ------------------------------------------------------------------------
    longint                      frame_vals [wht_pkg::DEPTH];
    logic [wht_pkg::LOG_W-1:0]   log_size_reg = 4'd10;
    bit                          inverse_reg  = 1'b0;
    int                          load_count   = 0;
    int                          read_count   = 0;
    bit                          frame_ready  = 1'b0;
    int                          useful_items = 0;
    wht_pkg::t_out_item          expected_coefs [$];
    int                          errors       = 0;

    function automatic int active_log();
        return (log_size_reg > wht_pkg::LOG_MAX) ? wht_pkg::LOG_MAX : int'(log_size_reg);
    endfunction

    // upper bound on the butterfly pass for the current size, plus margin
    function automatic int transform_cycles();
        int lg;
        lg = active_log();
        return 2 * (1 << lg) * lg + 32;
    endfunction

    function automatic void run_butterflies(int lg);
        int     n;
        int     span;
        int     base;
        int     k;
        longint a;
        longint b;
        n = 1 << lg;
        for (span = 1; span < n; span = span << 1) begin
            for (base = 0; base < n; base += 2 * span) begin
                for (k = 0; k < span; k++) begin
                    a = frame_vals[base + k];
                    b = frame_vals[base + span + k];
                    frame_vals[base + k]        = a + b;
                    frame_vals[base + span + k] = a - b;
                end
            end
        end
        // arithmetic shift floors negative values
        if (inverse_reg) begin
            for (k = 0; k < n; k++) frame_vals[k] = frame_vals[k] >>> lg;
        end
    endfunction

    function automatic void apply_register_write(logic idx, logic [31:0] value);
        if (idx == wht_pkg::REG_LOG_SIZE) begin
            log_size_reg = value[wht_pkg::LOG_W-1:0];
            load_count   = 0;
            read_count   = 0;
            frame_ready  = 1'b0;
        end else begin
            inverse_reg = value[0];
        end
    endfunction

    function automatic void predict_coefficients(wht_pkg::t_in_item item);
        int                 lg;
        int                 n;
        wht_pkg::t_out_item res;
        lg = active_log();
        n  = 1 << lg;
        if (item.kind == wht_pkg::KIND_LOAD) begin
            useful_items++;
            // a load during readout drops the rest of the frame
            if (frame_ready) begin
                frame_ready = 1'b0;
                read_count  = 0;
                load_count  = 0;
            end
            if (load_count >= n) load_count = 0;
            frame_vals[load_count] = longint'($signed(item.sample));
            load_count++;
            if (load_count >= n) begin
                run_butterflies(lg);
                load_count  = 0;
                read_count  = 0;
                frame_ready = 1'b1;
            end
        end else if (frame_ready && read_count < n) begin
            useful_items++;
            res.coefficient = frame_vals[read_count][wht_pkg::COEF_W-1:0];
            res.position    = read_count[wht_pkg::POS_W-1:0];
            res.last        = (read_count == n - 1);
            expected_coefs.push_back(res);
            read_count++;
            if (read_count >= n) begin
                read_count  = 0;
                frame_ready = 1'b0;
            end
        end
    endfunction

    function automatic void check_coefficient(wht_pkg::t_out_item got);
        wht_pkg::t_out_item want;
        if (expected_coefs.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: coef %0d pos %0d last %0d",
                         got.coefficient, got.position, got.last);
        end else begin
            want = expected_coefs.pop_front();
            if (got.coefficient !== want.coefficient || got.position !== want.position
                    || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected coef %0d pos %0d last %0d, got %0d %0d %0d",
                             want.coefficient, want.position, want.last,
                             got.coefficient, got.position, got.last);
            end
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (psel && penable && pwrite && pready) apply_register_write(paddr[2], pwdata);
            if (in_valid && !in_stall) predict_coefficients(in_data);
            if (out_valid && !out_stall) check_coefficient(out_data);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transfer of any kind
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** walsh_hadamard_transform_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall pattern, with a long hold-off on request
    // ------------------------------------------------------------------------
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int stall_mode = 0;
    int mode_left  = 0;

    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 120);
                end
                mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    int burst_left = 0;
    bit no_gaps    = 1'b0;

    task automatic send_item(logic kind, logic [wht_pkg::SAMPLE_W-1:0] sample);
        int                gap;
        wht_pkg::t_in_item item;
        if (!no_gaps && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        if (burst_left > 0) burst_left--;
        item.kind   = kind;
        item.sample = sample;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic load_sample(logic [wht_pkg::SAMPLE_W-1:0] sample);
        send_item(wht_pkg::KIND_LOAD, sample);
    endtask

    task automatic request_coef();
        send_item(wht_pkg::KIND_READ, wht_pkg::SAMPLE_W'($urandom));
    endtask

    function automatic logic [wht_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return wht_pkg::SAMPLE_W'($urandom_range(0, 2)) - 16'd1;
            default: return wht_pkg::SAMPLE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // all results in, and any butterfly pass started by the last load finished
    task automatic wait_frame_idle();
        end_burst();
        while (expected_coefs.size() != 0) @(posedge clk);
        repeat (transform_cycles()) @(posedge clk);
    endtask

    task automatic set_register(logic idx, logic [31:0] value);
        wait_frame_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_single_sample_frames();
        request_coef();                 // nothing loaded yet
        set_register(wht_pkg::REG_LOG_SIZE, 32'd0);
        set_register(wht_pkg::REG_INVERSE, 32'd1);
        load_sample(16'h7FFF);
        request_coef();
        request_coef();                 // past the end
        load_sample(16'h8000);
        request_coef();
        load_sample(16'h0001);
        load_sample(16'hFFFF);          // replaces the unread frame
        request_coef();
        wait_frame_idle();
    endtask

    task automatic test_short_frames();
        set_register(wht_pkg::REG_LOG_SIZE, 32'd2);
        request_coef();
        load_sample(16'h7FFF);
        load_sample(16'h8000);
        load_sample(16'h0001);
        load_sample(16'hFFFF);
        request_coef();
        request_coef();
        // new frame while the old one is half read
        repeat (4) load_sample(rand_sample());
        repeat (5) request_coef();
        // log_size write drops a partial frame
        repeat (3) load_sample(rand_sample());
        set_register(wht_pkg::REG_LOG_SIZE, 32'd1);
        load_sample(16'h8000);
        // inverse change lands on the frame that completes next
        set_register(wht_pkg::REG_INVERSE, 32'd0);
        load_sample(16'h7FFF);
        repeat (2) request_coef();
        wait_frame_idle();
    endtask

    task automatic test_long_frames();
        set_register(wht_pkg::REG_LOG_SIZE, 32'd8);
        repeat (256) load_sample(rand_sample());
        repeat (12) request_coef();
        wait_frame_idle();
    endtask

    task automatic test_output_hold_off();
        set_register(wht_pkg::REG_LOG_SIZE, 32'd4);
        repeat (16) load_sample(rand_sample());
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        repeat (16) request_coef();
        no_gaps  = 1'b0;
        wait_frame_idle();
    endtask

    task automatic test_random_frames();
        int target;
        int n;
        int reads;
        target = useful_items + 120;
        while (useful_items < target) begin
            case ($urandom_range(0, 9))
                0: begin
                    set_register(wht_pkg::REG_LOG_SIZE, $urandom_range(0, 5));
                    if ($urandom_range(0, 1))
                        set_register(wht_pkg::REG_INVERSE, $urandom_range(0, 1));
                end
                8, 9: begin
                    repeat ($urandom_range(1, 8))
                        send_item(1'($urandom_range(0, 1)), wht_pkg::SAMPLE_W'($urandom));
                end
                default: begin
                    n = 1 << active_log();
                    repeat (n) load_sample(rand_sample());
                    reads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n)
                                                        : n + $urandom_range(0, 2);
                    repeat (reads) request_coef();
                end
            endcase
        end
        wait_frame_idle();
    endtask

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sample_frames();
        test_short_frames();
        test_long_frames();
        test_output_hold_off();
        test_random_frames();

        if (errors == 0 && expected_coefs.size() == 0) begin
            $display("** walsh_hadamard_transform_core: PASSED **");
        end else begin
            $display("** walsh_hadamard_transform_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
